// ===== src/sorted_insertion_buffer_top_defines.svh =====
// Assertion macros used by the sorted insertion buffer controller (sib_ctrl).
`ifndef SORTED_INSERTION_BUFFER_TOP_DEFINES_SVH
`define SORTED_INSERTION_BUFFER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define SIB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define SIB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SIB_ASSERT_IMP(lbl, ante, cons, msg)

`define SIB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/sib_pkg.sv =====
package sib_pkg;

  localparam int unsigned SibDepth = 32;
  localparam int unsigned SibDataW = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } sib_state_e;

  // Load request from the controller to the output register.
  typedef struct packed {
    logic load;
    logic final_res;
    logic dropped;
  } sib_emit_t;

endpackage

// ===== src/sorted_insertion_buffer_top.sv =====
// Channel  Dir  Transfer       Payload
// s_*      in   value          tdata[31:0] = value, tlast = batch_end
// m_*      out  sorted result  tdata[31:0] = sorted_value, tlast = final_res, tuser = dropped
//
// Inserting a value into a store of n > 0 entries scans past the stored entries larger than it:
// the scan walks down from the top entry, one RAM read and one write per cycle, shifting each
// larger entry up by one. The first value of a batch is written straight into the store, and a
// value at a full store is dropped without a scan. A batch end then reads the first
// entry and streams the n entries out at one transfer per cycle while m_tready_i is high.
// The output register keeps a result while m_tready_i is low and the stream waits; once the last
// result is loaded, a new value is taken while it waits.
// Reset clears the entry count and the drop flag; the store itself is not cleared.
module sorted_insertion_buffer_top import sib_pkg::*; #(
  parameter int unsigned Depth = SibDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic signed [SibDataW-1:0] s_tdata_i,   // [31:0] value
  input  logic                       s_tlast_i,   // batch_end
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic signed [SibDataW-1:0] m_tdata_o,   // [31:0] sorted_value
  output logic                       m_tlast_o,   // final_res
  output logic                       m_tuser_o    // [0] dropped
);

  localparam int unsigned IW = $clog2(Depth);

  sib_emit_t                  emit;
  logic                       out_free;
  logic                       ram_wr_en;
  logic [IW-1:0]              ram_wr_addr;
  logic [SibDataW-1:0]        ram_wr_data;
  logic                       ram_rd_en;
  logic [IW-1:0]              ram_rd_addr;
  logic [SibDataW-1:0]        ram_rd_data;

  logic                       m_valid_q;
  logic signed [SibDataW-1:0] m_data_q;
  logic                       m_last_q;
  logic                       m_drop_q;

  assign out_free = !m_valid_q || m_tready_i;

  sib_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid_i),
    .s_tready_o    (s_tready_o),
    .s_value_i     (s_tdata_i),
    .s_batch_end_i (s_tlast_i),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data)
  );

  sib_ram #(
    .Width(SibDataW),
    .Depth(Depth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit.load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      m_data_q <= $signed(ram_rd_data);
      m_last_q <= emit.final_res;
      m_drop_q <= emit.dropped;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_drop_q;

endmodule

// ===== src/sib_ram.sv =====
module sib_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/sib_ctrl.sv =====
`include "sorted_insertion_buffer_top_defines.svh"

module sib_ctrl import sib_pkg::*; #(
  parameter int unsigned Depth = SibDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic signed [SibDataW-1:0] s_value_i,
  input  logic                       s_batch_end_i,
  input  logic                       out_free_i,
  output sib_emit_t                  emit_o,
  output logic                       ram_wr_en_o,
  output logic [$clog2(Depth)-1:0]   ram_wr_addr_o,
  output logic [SibDataW-1:0]        ram_wr_data_o,
  output logic                       ram_rd_en_o,
  output logic [$clog2(Depth)-1:0]   ram_rd_addr_o,
  input  logic [SibDataW-1:0]        ram_rd_data_i
);

  localparam int unsigned IW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  sib_state_e                 state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [IW-1:0]              idx_q, idx_d;
  logic signed [SibDataW-1:0] new_q, new_d;
  logic                       last_q, last_d;
  logic                       ovf_q, ovf_d;

  logic accept;
  logic full;
  logic empty;
  logic greater;
  logic is_final;
  logic idx_zero;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign full       = (cnt_q == CW'(Depth));
  assign empty      = (cnt_q == '0);
  assign idx_zero   = (idx_q == '0);
  // A stored value strictly above the new one moves up; equal values stay below it.
  assign greater    = ($signed(ram_rd_data_i) > new_q);
  assign is_final   = (idx_q == IW'(cnt_q - CW'(1)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full || empty) begin
            state_d = s_batch_end_i ? ST_EMIT_RD : ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!greater) begin
          state_d = last_q ? ST_EMIT_RD : ST_IDLE;
        end else if (idx_zero) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        state_d = last_q ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free_i && is_final) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = '0;
    ram_wr_data_o = new_q;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = '0;
    emit_o        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && empty) begin
          ram_wr_en_o   = 1'b1;
          ram_wr_data_o = s_value_i;
        end else if (accept && !full) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = IW'(cnt_q - CW'(1));
        end
      end
      ST_SCAN: begin
        // Shift the entry just read up by one, or drop the new value into the gap.
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = idx_q + IW'(1);
        ram_wr_data_o = greater ? ram_rd_data_i : new_q;
        if (greater && !idx_zero) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = idx_q - IW'(1);
        end
      end
      ST_PUT: begin
        ram_wr_en_o = 1'b1;
      end
      ST_EMIT_RD: begin
        ram_rd_en_o = 1'b1;
      end
      ST_EMIT_LD: begin
        if (out_free_i) begin
          emit_o.load      = 1'b1;
          emit_o.final_res = is_final;
          emit_o.dropped   = ovf_q;
          if (!is_final) begin
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = idx_q + IW'(1);
          end
        end
      end
      default: begin
        ram_wr_en_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    new_d  = new_q;
    last_d = last_q;
    ovf_d  = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          new_d  = s_value_i;
          last_d = s_batch_end_i;
          if (full) begin
            ovf_d = 1'b1;
          end else if (empty) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            idx_d = IW'(cnt_q - CW'(1));
          end
        end
      end
      ST_SCAN: begin
        if (!greater) begin
          cnt_d = cnt_q + CW'(1);
        end else if (!idx_zero) begin
          idx_d = idx_q - IW'(1);
        end
      end
      ST_PUT: begin
        cnt_d = cnt_q + CW'(1);
      end
      ST_EMIT_RD: begin
        idx_d = '0;
      end
      ST_EMIT_LD: begin
        if (out_free_i) begin
          if (is_final) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
  end

  `SIB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(Depth), "entry count above depth")
  `SIB_ASSERT_IMP(a_scan_idx, state_q == ST_SCAN, CW'(idx_q) < cnt_q, "scan index out of range")
  `SIB_ASSERT_IMP(a_no_rw_clash, ram_wr_en_o && ram_rd_en_o, ram_wr_addr_o != ram_rd_addr_o,
                  "read and write of the same entry in one cycle")
  `SIB_ASSERT_NXT(a_batch_clear, emit_o.load && emit_o.final_res,
                  cnt_q == '0 && !ovf_q && state_q == ST_IDLE, "batch not cleared after last result")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sib_pkg::*;

  localparam int unsigned StoreDepth = SibDepth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 80;

  typedef struct {
    logic signed [SibDataW-1:0] value;
    logic                       final_res;
    logic                       dropped;
  } sorted_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_tvalid_i = 1'b0;
  logic                       s_tready_o;
  logic signed [SibDataW-1:0] s_tdata_i = '0;
  logic                       s_tlast_i = 1'b0;
  logic                       m_tvalid_o;
  logic                       m_tready_i = 1'b0;
  logic signed [SibDataW-1:0] m_tdata_o;
  logic                       m_tlast_o;
  logic                       m_tuser_o;

  // Mirror of the batch currently held by the block, kept in ascending order.
  logic signed [SibDataW-1:0] batch_entries[$];
  logic                       batch_dropped = 1'b0;
  sorted_result_t             sorted_expect[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;
  logic        no_idle = 1'b0;

  sorted_insertion_buffer_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tlast_i (s_tlast_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o),
    .m_tuser_o (m_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** sorted_insertion_buffer_top: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SibDataW-1:0] rand_value();
    logic signed [SibDataW-1:0] value;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        value = $urandom;
      end
      6, 7: begin
        // Narrow range so that batches hold many equal values.
        value = $signed($urandom_range(0, 8)) - 4;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: value = 32'sh80000000;
          1: value = 32'sh7FFFFFFF;
          2: value = '0;
          default: value = -1;
        endcase
      end
      default: begin
        value = $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                     : 32'sh80000000 + $urandom_range(0, 3);
      end
    endcase
    return value;
  endfunction

  // Stable insert: a new value goes after every stored value equal to it.
  function automatic void predict_insert(logic signed [SibDataW-1:0] value, logic batch_end);
    int unsigned    pos;
    sorted_result_t res;
    pos = 0;
    if (batch_entries.size() >= StoreDepth) begin
      batch_dropped = 1'b1;
    end else begin
      while (pos < batch_entries.size() && batch_entries[pos] <= value) pos++;
      batch_entries.insert(pos, value);
    end
    if (batch_end) begin
      foreach (batch_entries[k]) begin
        res.value     = batch_entries[k];
        res.final_res = (k == batch_entries.size() - 1);
        res.dropped   = batch_dropped;
        sorted_expect.push_back(res);
      end
      batch_entries.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [SibDataW-1:0] want,
                                 input logic [SibDataW-1:0] got);
    $display("cycle %0d: %s mismatch, expected %h, got %h", cycle_count, field, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    sorted_result_t want;
    if (sorted_expect.size() == 0) begin
      report_mismatch("unexpected result", '0, m_tdata_o);
      return;
    end
    want = sorted_expect.pop_front();
    if (m_tdata_o !== want.value) report_mismatch("sorted_value", want.value, m_tdata_o);
    if (m_tlast_o !== want.final_res) report_mismatch("final_res", want.final_res, m_tlast_o);
    if (m_tuser_o !== want.dropped) report_mismatch("dropped", want.dropped, m_tuser_o);
  endtask

  // Result side: check each transfer and stall the output at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) check_result();
      if (ready_hold != 0) begin
        ready_hold <= ready_hold - 1;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
      end
    end
  end

  task automatic push_value(input logic signed [SibDataW-1:0] value, input logic batch_end);
    int unsigned gap;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= value;
    s_tlast_i  <= batch_end;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    predict_insert(value, batch_end);
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic test_extremes();
    push_value(32'sh7FFFFFFF, 1'b0);
    push_value(32'sh80000000, 1'b0);
    push_value(32'sh00000000, 1'b0);
    push_value(32'shFFFFFFFF, 1'b0);
    push_value(32'sh00000001, 1'b0);
    push_value(32'shAAAAAAAA, 1'b0);
    push_value(32'sh55555555, 1'b1);
    // Batches of a single value.
    push_value(32'sh80000000, 1'b1);
    push_value(32'sh7FFFFFFF, 1'b1);
  endtask

  task automatic test_duplicates_and_order();
    push_value(5, 1'b0);
    push_value(-3, 1'b0);
    push_value(5, 1'b0);
    push_value(5, 1'b0);
    push_value(-3, 1'b0);
    push_value(5, 1'b1);
    // Descending input makes every insert shift the whole store.
    for (int v = 4; v >= 0; v--) push_value(v, v == 0);
    for (int v = -2; v <= 2; v++) push_value(v, v == 2);
  endtask

  task automatic test_full_store();
    // Exactly full: the final value still fits, nothing is dropped.
    no_idle = 1'b1;
    for (int i = 0; i < StoreDepth; i++) push_value(rand_value(), i == StoreDepth - 1);
    no_idle = 1'b0;
    // The final value arrives at a full store and is dropped.
    for (int i = 0; i <= StoreDepth; i++) push_value(rand_value(), i == StoreDepth);
    // Several values dropped before the batch ends.
    for (int i = 0; i < StoreDepth + 4; i++) push_value(rand_value(), i == StoreDepth + 3);
  endtask

  task automatic test_random_batches();
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < 110) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        len = $urandom_range(1, 8);
      end else if (r < 18) begin
        len = $urandom_range(9, 24);
      end else begin
        len = $urandom_range(28, 40);
      end
      for (int unsigned i = 0; i < len; i++) push_value(rand_value(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_duplicates_and_order();
    test_full_store();
    test_random_batches();
    s_tvalid_i <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && sorted_expect.size() == 0) begin
      $display("** sorted_insertion_buffer_top: PASSED **");
    end else begin
      $display("** sorted_insertion_buffer_top: FAILED **");
    end
    $finish;
  end

endmodule
